FILE: rtl/dht_pkg.sv
// Package for the double hash table engine: request/response types, codes,
// hash constants and a MurmurHash3 rotate helper function.
// No dependencies.
`default_nettype none
package dht_pkg;

   localparam int DefTableSlots = 1031;
   localparam int DefValueBits  = 64;
   localparam int KeyBits       = 64;
   localparam int LiveBits      = 11;

   localparam logic [31:0] Seed = 32'h811c9dc5;
   localparam logic [31:0] C1   = 32'hcc9e2d51;
   localparam logic [31:0] C2   = 32'h1b873593;
   localparam logic [31:0] Nadd = 32'he6546b64;
   localparam logic [31:0] F1   = 32'h85ebca6b;
   localparam logic [31:0] F2   = 32'hc2b2ae35;

   typedef enum logic [1:0] {
      FUNC_PUT    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_LIVE  = 2'd1,
      MARK_DEAD  = 2'd2
   } mark_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] value_out;
      logic [10:0] live_entries;
   } rsp_type;

   // Item passed from the front (hash) to the back (probe) through the queue.
   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key;
      logic [63:0] value;
      logic [63:0] kmask;
      logic [31:0] hash;
   } job_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction

endpackage
`default_nettype wire

FILE: rtl/dht_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module dht_ram #(
   parameter int Width = 64,
   parameter int Depth = 1031
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/dht_front.sv
// Front end: takes requests, masks the key and computes MurmurHash3 (one
// multiply per cycle). Depends on dht_pkg.
`default_nettype none
module dht_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire dht_pkg::req_type req_data,
   input  wire logic [3:0]       key_bytes,
   output logic                  job_valid,
   output dht_pkg::job_type      job_data,
   input  wire logic             job_ready
);
   import dht_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_KA, S_KB, S_MIX, S_FA, S_FB, S_FC, S_OUT
   } state_type;

   state_type   state_ff;
   logic [1:0]  func_ff;
   logic [63:0] key_ff, value_ff, kmask_ff;
   logic [31:0] h_ff, k_ff;
   logic [3:0]  len_ff;
   logic        blk_ff;   // 0: first word, 1: second word
   logic        tail_ff;  // current word is the tail block
   logic [3:0]  len_c;
   logic [63:0] kmask_c;
   logic [31:0] h_mix, word_c, k_rot, h_fin;

   always_comb begin
      len_c = key_bytes;
      if (len_c == 4'd0) len_c = 4'd1;
      if (len_c > 4'd8)  len_c = 4'd8;
      kmask_c = ~64'd0 >> (7'd64 - {len_c, 3'b000});
   end

   assign word_c = blk_ff ? key_ff[63:32] : key_ff[31:0];
   assign k_rot  = rotl32(k_ff, 15);
   assign h_mix  = h_ff ^ k_ff;
   assign h_fin  = h_ff ^ {28'd0, len_ff};

   assign busy      = state_ff != S_IDLE;
   assign job_valid = state_ff == S_OUT;
   assign job_data  = '{func: func_ff, key: key_ff, value: value_ff,
                        kmask: kmask_ff, hash: h_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff  <= req_data.func;
                  key_ff   <= req_data.key & kmask_c;
                  value_ff <= req_data.value;
                  kmask_ff <= kmask_c;
                  len_ff   <= len_c;
                  h_ff     <= Seed;
                  blk_ff   <= 1'b0;
                  tail_ff  <= len_c < 4'd4;
                  state_ff <= S_KA;
               end
            end
            S_KA: begin
               k_ff     <= word_c * C1;
               state_ff <= S_KB;
            end
            S_KB: begin
               k_ff     <= k_rot * C2;
               state_ff <= S_MIX;
            end
            S_MIX: begin
               if (tail_ff) begin
                  h_ff     <= h_mix;
                  state_ff <= S_FA;
               end else begin
                  h_ff <= rotl32(h_mix, 13) * 32'd5 + Nadd;
                  // next word: second block or tail, if any bytes remain
                  if (!blk_ff && len_ff > 4'd4) begin
                     blk_ff   <= 1'b1;
                     tail_ff  <= len_ff < 4'd8;
                     state_ff <= S_KA;
                  end else begin
                     state_ff <= S_FA;
                  end
               end
            end
            S_FA: begin
               h_ff     <= (h_fin ^ (h_fin >> 16)) * F1;
               state_ff <= S_FB;
            end
            S_FB: begin
               k_ff     <= (h_ff ^ (h_ff >> 13)) * F2;
               state_ff <= S_FC;
            end
            S_FC: begin
               h_ff     <= k_ff ^ (k_ff >> 16);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (job_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/dht_queue.sv
// Two-entry queue between the hash front end and the probe back end.
// Depends on dht_pkg.
`default_nettype none
module dht_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dht_pkg::job_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output dht_pkg::job_type      head
);
   import dht_pkg::*;

   job_type    q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

FILE: rtl/dht_back.sv
// Back end: clearing pass, double-hash probe over the slot memories and
// the update of the table. Depends on dht_pkg and dht_ram.
`default_nettype none
module dht_back #(
   parameter int TableSlots = dht_pkg::DefTableSlots,
   parameter int ValueBits  = dht_pkg::DefValueBits
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire dht_pkg::job_type job_data,
   output logic                  job_pop,
   output logic                  ready,
   output logic                  rsp_strobe,
   output dht_pkg::rsp_type      rsp_data
);
   import dht_pkg::*;

   localparam int AW = $clog2(TableSlots);
   localparam int HW = 32;
   localparam int RS = HW + AW - 1;
   // reciprocals of both moduli, scaled by 2^RS
   localparam logic [HW:0] Recip1 = (HW+1)'((64'd1 << RS) / 64'(TableSlots));
   localparam logic [HW:0] Recip2 = (HW+1)'((64'd1 << RS) / 64'(TableSlots - 1));

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MOD1, S_MOD2, S_ADDR, S_READ, S_EVAL, S_FINISH,
      S_WRITE, S_RESP
   } state_type;

   state_type         state_ff;
   job_type           job_ff;
   logic [AW-1:0]     addr_ff, idx_ff, step_ff, dead_ff, clr_ff;
   logic [2*HW:0]     p1_ff, p2_ff;
   logic [HW:0]       r1_ff, r2_ff;
   logic [AW:0]       iter_ff;
   logic              have_dead_ff;
   logic [2:0]        status_ff;
   logic [63:0]       vout_ff;
   logic [10:0]       live_ff;
   logic [AW-1:0]     wr_addr_ff;
   logic              wr_mark_ff, wr_kv_ff, wr_val_only_ff;
   logic [1:0]        wr_markv_ff;

   logic              mark_we, kv_we, val_we;
   logic [AW-1:0]     ram_addr;
   logic [1:0]        mark_wd, mark_rd;
   logic [63:0]       key_rd;
   logic [ValueBits-1:0] val_rd, val_wd;
   logic [AW:0]       idx_sum;
   logic [AW-1:0]     first_c, step_c;

   assign val_wd = job_ff.value[ValueBits-1:0];

   always_comb begin
      ram_addr = addr_ff;
      mark_we  = 1'b0;
      kv_we    = 1'b0;
      val_we   = 1'b0;
      mark_wd  = wr_markv_ff;
      if (state_ff == S_CLEAR) begin
         ram_addr = clr_ff;
         mark_we  = 1'b1;
         mark_wd  = MARK_EMPTY;
      end else if (state_ff == S_WRITE) begin
         ram_addr = wr_addr_ff;
         mark_we  = wr_mark_ff;
         kv_we    = wr_kv_ff;
         val_we   = wr_kv_ff | wr_val_only_ff;
      end
   end

   dht_ram #(.Width(2), .Depth(TableSlots)) u_mark (
      .clock(clock), .we(mark_we), .addr(ram_addr), .wdata(mark_wd), .rdata(mark_rd));
   dht_ram #(.Width(64), .Depth(TableSlots)) u_key (
      .clock(clock), .we(kv_we), .addr(ram_addr), .wdata(job_ff.key), .rdata(key_rd));
   dht_ram #(.Width(ValueBits), .Depth(TableSlots)) u_val (
      .clock(clock), .we(val_we), .addr(ram_addr), .wdata(val_wd), .rdata(val_rd));

   // first slot and step: quotient estimate by reciprocal multiply is at most
   // one short, so one compare and subtract finishes each remainder
   assign first_c = (r1_ff >= (HW+1)'(TableSlots)) ?
                    AW'(r1_ff - (HW+1)'(TableSlots)) : r1_ff[AW-1:0];
   assign step_c  = (r2_ff >= (HW+1)'(TableSlots - 1)) ?
                    AW'(r2_ff - (HW+1)'(TableSlots - 1)) : r2_ff[AW-1:0];
   assign idx_sum = {1'b0, idx_ff} + {1'b0, step_ff};

   assign ready    = state_ff == S_IDLE;
   assign job_pop  = ready && job_valid;
   assign rsp_strobe = state_ff == S_RESP;
   assign rsp_data = '{status: status_ff, value_out: vout_ff, live_entries: live_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         live_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(TableSlots - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (job_valid) begin
                  job_ff <= job_data;
                  if (job_data.func == FUNC_NONE) begin
                     status_ff <= ST_NOT_FOUND;
                     vout_ff   <= '0;
                     state_ff  <= S_RESP;
                  end else begin
                     state_ff <= S_MOD1;
                  end
               end
            end
            S_MOD1: begin
               p1_ff    <= (2*HW+1)'(job_ff.hash) * (2*HW+1)'(Recip1);
               p2_ff    <= (2*HW+1)'(job_ff.hash) * (2*HW+1)'(Recip2);
               state_ff <= S_MOD2;
            end
            S_MOD2: begin
               r1_ff <= {1'b0, job_ff.hash} -
                        (HW+1)'(p1_ff[2*HW:RS]) * (HW+1)'(TableSlots);
               r2_ff <= {1'b0, job_ff.hash} -
                        (HW+1)'(p2_ff[2*HW:RS]) * (HW+1)'(TableSlots - 1);
               state_ff <= S_ADDR;
            end
            S_ADDR: begin
               idx_ff       <= first_c;
               addr_ff      <= first_c;
               step_ff      <= step_c + 1'b1;
               iter_ff      <= '0;
               have_dead_ff <= 1'b0;
               status_ff    <= ST_NOT_FOUND;
               vout_ff      <= '0;
               wr_mark_ff   <= 1'b0;
               wr_kv_ff     <= 1'b0;
               wr_val_only_ff <= 1'b0;
               state_ff     <= S_READ;
            end
            S_READ: state_ff <= S_EVAL;
            S_EVAL: begin
               idx_ff  <= (idx_sum >= (AW+1)'(TableSlots)) ?
                          AW'(idx_sum - (AW+1)'(TableSlots)) : idx_sum[AW-1:0];
               iter_ff <= iter_ff + 1'b1;
               state_ff <= S_READ;
               if (mark_rd == MARK_DEAD) begin
                  if (!have_dead_ff) begin
                     have_dead_ff <= 1'b1;
                     dead_ff      <= addr_ff;
                  end
               end else if (mark_rd == MARK_LIVE) begin
                  if ((key_rd & job_ff.kmask) == job_ff.key) begin
                     wr_addr_ff <= addr_ff;
                     state_ff   <= S_WRITE;
                     case (job_ff.func)
                        FUNC_PUT: begin
                           wr_val_only_ff <= 1'b1;
                           status_ff      <= ST_UPDATED;
                        end
                        FUNC_REMOVE: begin
                           wr_mark_ff  <= 1'b1;
                           wr_markv_ff <= MARK_DEAD;
                           live_ff     <= live_ff - 1'b1;
                           status_ff   <= ST_REMOVED;
                        end
                        default: begin
                           vout_ff   <= 64'(val_rd);
                           status_ff <= ST_FOUND;
                        end
                     endcase
                  end
               end else begin
                  state_ff <= S_WRITE;
                  if (job_ff.func == FUNC_PUT) begin
                     wr_addr_ff  <= have_dead_ff ? dead_ff : addr_ff;
                     wr_mark_ff  <= 1'b1;
                     wr_kv_ff    <= 1'b1;
                     wr_markv_ff <= MARK_LIVE;
                     live_ff     <= live_ff + 1'b1;
                     status_ff   <= ST_INSERTED;
                  end
               end
               if (state_ff == S_EVAL && iter_ff == (AW+1)'(TableSlots - 1) &&
                   !(mark_rd == MARK_EMPTY) &&
                   !(mark_rd == MARK_LIVE && (key_rd & job_ff.kmask) == job_ff.key)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // whole sequence probed without an empty slot
               state_ff <= S_WRITE;
               if (job_ff.func == FUNC_PUT) begin
                  if (have_dead_ff) begin
                     wr_addr_ff  <= dead_ff;
                     wr_mark_ff  <= 1'b1;
                     wr_kv_ff    <= 1'b1;
                     wr_markv_ff <= MARK_LIVE;
                     live_ff     <= live_ff + 1'b1;
                     status_ff   <= ST_INSERTED;
                  end else begin
                     status_ff <= ST_FULL;
                  end
               end
            end
            S_WRITE: state_ff <= S_RESP;
            S_RESP:  state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_EVAL) addr_ff <= (idx_sum >= (AW+1)'(TableSlots)) ?
            AW'(idx_sum - (AW+1)'(TableSlots)) : idx_sum[AW-1:0];
      end
   end
endmodule
`default_nettype wire

FILE: rtl/double_hash_table_engine_top.sv
// Top level of the double hash table engine.
// Depends on dht_pkg, dht_front, dht_queue, dht_back and dht_ram.
`default_nettype none
// Usage
//   Requests: drive req_data (func, key, value) and raise start; the
//   transaction is taken at a clock edge where start is high and busy low.
//   Responses: rsp_strobe marks rsp_data for exactly one cycle; the
//   receiver cannot stall, so every response is simply presented once.
//   Configuration: csr_we with csr_wdata[3:0] writes key_bytes (reset 4);
//   write only while the engine is idle.
// Structure
//   The front end hashes (MurmurHash3, one 32x32 multiply per cycle), a
//   second block for keys over four bytes, and takes a new transaction only
//   once the last one is in the queue. A two-entry queue decouples it from
//   the back end, which finds first slot and step by reciprocal multiply
//   (MOD1, MOD2, ADDR) and then probes one slot at a time (read, then compare).
// Operations
//   The unused operation answers ST_NOT_FOUND without a probe. The back end
//   pops the next transaction only once it is idle again after a response.
// Reset
//   Synchronous, active high. The back end then clears the slot-mark
//   memory, one slot per cycle; requests queue up in the meantime and are
//   served afterwards.
module double_hash_table_engine_top #(
   parameter int TableSlots = dht_pkg::DefTableSlots,
   parameter int ValueBits  = dht_pkg::DefValueBits
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire dht_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output dht_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [3:0]       csr_wdata
);
   import dht_pkg::*;

   logic [3:0] kb_ff;
   job_type    fr_job, q_head;
   logic       fr_valid, q_full, q_ne, q_pop, bk_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kb_ff <= 4'd4;
      end else begin
         if (csr_we) kb_ff <= csr_wdata;
      end
   end

   dht_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .key_bytes(kb_ff), .job_valid(fr_valid),
      .job_data(fr_job), .job_ready(!q_full));

   dht_queue u_queue (
      .clock(clock), .reset(reset), .push(fr_valid && !q_full), .push_data(fr_job),
      .full(q_full), .pop(q_pop), .not_empty(q_ne), .head(q_head));

   dht_back #(.TableSlots(TableSlots), .ValueBits(ValueBits)) u_back (
      .clock(clock), .reset(reset), .job_valid(q_ne), .job_data(q_head),
      .job_pop(q_pop), .ready(bk_ready), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data));

   ap_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_ne) else $error("queue popped while empty");
   ap_pop_ready: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> bk_ready) else $error("pop outside back-end idle");
   ap_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("response strobe held");
   ap_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.status <= ST_FULL) else $error("status code out of range");
endmodule
`default_nettype wire
